// File: rtl/polled_node_response_deframer_unit_assert.svh
// Assertion macros for the polled node response deframer.
// Included by pndf_parser, the one RTL module that carries concurrent checks; no other dependencies.
`ifndef POLLED_NODE_RESPONSE_DEFRAMER_UNIT_ASSERT_SVH
`define POLLED_NODE_RESPONSE_DEFRAMER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside of reset.
`define PNDF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");

// Next-cycle implication, checked outside of reset.
`define PNDF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

// File: rtl/pndf_pkg.sv
// Shared types and constants of the polled node response deframer.
// No dependencies; imported by every module of the block.
package pndf_pkg;

    // Framing bytes of the node reply.
    localparam logic [7:0] FR_SYN      = 8'hFF;
    localparam logic [7:0] FR_STX      = 8'h02;
    localparam logic [7:0] FR_ETX      = 8'h03;
    localparam logic [7:0] FR_DLE      = 8'h10;
    localparam logic [7:0] ADDR_OFFSET = 8'd65;
    localparam logic [7:0] TYPE_REPLY  = 8'h52;

    // Input beat action codes.
    localparam logic [1:0] ACT_POLL    = 2'd0;
    localparam logic [1:0] ACT_BYTE    = 2'd1;
    localparam logic [1:0] ACT_TIMEOUT = 2'd2;

    // Result beat kind codes.
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    // Frame parser states.
    typedef enum logic [2:0] {
        PS_SYN1 = 3'd0,
        PS_SYN2 = 3'd1,
        PS_STX  = 3'd2,
        PS_ADDR = 3'd3,
        PS_TYPE = 3'd4,
        PS_DATA = 3'd5,
        PS_ESC  = 3'd6
    } ps_t;

    // One input item.
    typedef struct packed {
        logic [1:0] action;
        logic [7:0] rx_byte;
        logic [6:0] node_address;
    } item_t;

    // Handshake between the input stage and the parser.
    typedef struct packed {
        logic  valid;
        item_t item;
    } stage_t;

endpackage

// File: rtl/pndf_in_stage.sv
// Input register stage of the polled node response deframer.
// Depends on pndf_pkg for the item and stage types.
module pndf_in_stage
    import pndf_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   s_valid,
    output logic   s_ready,
    input  item_t  s_item,
    output stage_t stage,
    input  logic   stage_ready
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  load;

    // Register frees up whenever the parser takes its beat.
    assign s_ready = !valid_reg || stage_ready;
    assign load    = s_valid && s_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (stage_ready)
        begin
            valid_next = 1'b0;
        end
    end

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload holds while stalled.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= s_item;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

endmodule

// File: rtl/pndf_parser.sv
// Frame parser and result register of the polled node response deframer.
// Depends on pndf_pkg and the assertion macros header.
`include "polled_node_response_deframer_unit_assert.svh"

module pndf_parser
    import pndf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  stage_t     stage,
    output logic       stage_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] out_kind,
    output logic [7:0] out_data_byte,
    output logic [7:0] out_data_index
);

    logic       listening_reg;
    logic       listening_next;
    ps_t        state_reg;
    ps_t        state_next;
    ps_t        byte_next;
    logic [6:0] addr_reg;
    logic [6:0] addr_next;
    logic [7:0] pos_reg;
    logic [7:0] pos_next;
    logic       valid_reg;
    logic       valid_next;
    logic [1:0] kind_reg;
    logic [1:0] kind_next;
    logic [7:0] dbyte_reg;
    logic [7:0] dbyte_next;
    logic [7:0] dindex_reg;
    logic [7:0] dindex_next;
    logic       take;
    logic [7:0] addr_char;
    logic [7:0] b;

    // A beat is taken whenever the result register can accept its result.
    assign stage_ready = !valid_reg || out_ready;
    assign take        = stage.valid && stage_ready;
    assign b           = stage.item.rx_byte;
    assign addr_char   = {1'b0, addr_reg} + ADDR_OFFSET;

    // Parser next state and result for the beat at the stage head.
    always_comb
    begin
        listening_next = listening_reg;
        state_next     = state_reg;
        byte_next      = PS_SYN1;
        addr_next      = addr_reg;
        pos_next       = pos_reg;
        kind_next      = KIND_NONE;
        dbyte_next     = 8'd0;
        dindex_next    = 8'd0;
        case (stage.item.action)
            ACT_POLL:
            begin
                listening_next = 1'b1;
                addr_next      = stage.item.node_address;
            end
            ACT_TIMEOUT:
            begin
                listening_next = 1'b0;
                state_next     = PS_SYN1;
            end
            ACT_BYTE:
            begin
                if (listening_reg)
                begin
                    case (state_reg)
                        PS_SYN1:
                        begin
                            if (b == FR_SYN)
                            begin
                                byte_next = PS_SYN2;
                            end
                        end
                        PS_SYN2:
                        begin
                            // Anything but SYN keeps waiting for the second SYN.
                            byte_next = (b == FR_SYN) ? PS_STX : PS_SYN2;
                        end
                        PS_STX:
                        begin
                            if (b == FR_STX)
                            begin
                                byte_next = PS_ADDR;
                            end
                        end
                        PS_ADDR:
                        begin
                            if (b == addr_char)
                            begin
                                byte_next = PS_TYPE;
                            end
                        end
                        PS_TYPE:
                        begin
                            pos_next = 8'd0;
                            if (b == TYPE_REPLY)
                            begin
                                byte_next = PS_DATA;
                            end
                        end
                        PS_DATA:
                        begin
                            if (b == FR_DLE)
                            begin
                                byte_next = PS_ESC;
                            end
                            else if (b == FR_ETX)
                            begin
                                kind_next      = KIND_END;
                                listening_next = 1'b0;
                            end
                            else
                            begin
                                kind_next   = KIND_DATA;
                                dbyte_next  = b;
                                dindex_next = pos_reg;
                                pos_next    = pos_reg + 8'd1;
                                byte_next   = PS_DATA;
                            end
                        end
                        PS_ESC:
                        begin
                            kind_next   = KIND_DATA;
                            dbyte_next  = b;
                            dindex_next = pos_reg;
                            pos_next    = pos_reg + 8'd1;
                            byte_next   = PS_DATA;
                        end
                        default:
                        begin
                            byte_next = PS_SYN1;
                        end
                    endcase
                    state_next = byte_next;
                end
            end
            default:
            begin
                listening_next = listening_reg;
            end
        endcase
    end

    // Result register valid flag.
    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    // Parser state and control flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            listening_reg <= 1'b0;
            state_reg     <= PS_SYN1;
            addr_reg      <= 7'd0;
            pos_reg       <= 8'd0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (take)
            begin
                listening_reg <= listening_next;
                state_reg     <= state_next;
                addr_reg      <= addr_next;
                pos_reg       <= pos_next;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            kind_reg   <= kind_next;
            dbyte_reg  <= dbyte_next;
            dindex_reg <= dindex_next;
        end
    end

    assign out_valid      = valid_reg;
    assign out_kind       = kind_reg;
    assign out_data_byte  = dbyte_reg;
    assign out_data_index = dindex_reg;

    // A timeout always disarms and rewinds the parser.
    `PNDF_ASSERT_NEXT(a_timeout_rewinds, clk, rst_n,
        take && stage.item.action == ACT_TIMEOUT, !listening_reg && state_reg == PS_SYN1)
    // A poll always arms listening.
    `PNDF_ASSERT_NEXT(a_poll_arms, clk, rst_n,
        take && stage.item.action == ACT_POLL, listening_reg)
    // An end-of-message result leaves the parser disarmed.
    `PNDF_ASSERT_NOW(a_end_disarms, clk, rst_n,
        valid_reg && kind_reg == KIND_END, !listening_reg)
    // Bytes received while disarmed do not move the parser.
    `PNDF_ASSERT_NEXT(a_idle_bytes_ignored, clk, rst_n,
        take && !listening_reg && stage.item.action == ACT_BYTE,
        $stable(state_reg) && $stable(pos_reg))

endmodule

// File: rtl/polled_node_response_deframer_unit.sv
// Polled node response deframer: an accepted input beat passes the input register, then
// its result the result register, to the master side; one beat is accepted every cycle
// while m_axis_tready stays high, one result beat per input beat, from the single-pass
// parser between the registers. Reset (rst_n low, asynchronous) disarms listening, returns
// the parser to hunting the first SYN and empties both registers.
// Depends on pndf_pkg, pndf_in_stage and pndf_parser.
module polled_node_response_deframer_unit
    import pndf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [7:0] rx_byte, [14:8] node_address, [15] zero
    input  logic [1:0]  s_axis_tuser,  // [1:0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // [7:0] data_byte, [15:8] data_index
    output logic [1:0]  m_axis_tuser   // [1:0] kind
);

    item_t      s_item;
    stage_t     stage;
    logic       stage_ready;
    logic [7:0] data_byte;
    logic [7:0] data_index;

    // Unpack the slave-side beat.
    assign s_item.action       = s_axis_tuser;
    assign s_item.rx_byte      = s_axis_tdata[7:0];
    assign s_item.node_address = s_axis_tdata[14:8];

    pndf_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_valid     (s_axis_tvalid),
        .s_ready     (s_axis_tready),
        .s_item      (s_item),
        .stage       (stage),
        .stage_ready (stage_ready)
    );

    pndf_parser u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .stage          (stage),
        .stage_ready    (stage_ready),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_kind       (m_axis_tuser),
        .out_data_byte  (data_byte),
        .out_data_index (data_index)
    );

    // Pack the master-side beat.
    assign m_axis_tdata = {data_index, data_byte};

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the polled node response deframer unit.
// Depends on pndf_pkg and polled_node_response_deframer_unit; it reads no files.
`timescale 1ns / 1ps

module tb_top;
    import pndf_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEM_TARGET = 450;
    localparam int STEADY_TAIL = 70;
    localparam int WRAP_DATA_LEN = 260;
    localparam int LONG_HOLD_CYCLES = 40;
    localparam int REPORT_LIMIT = 10;
    localparam int N_DIRECTED = 29;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // One result beat, fields from the highest bits down.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [7:0] data_index;
    } reply_t;

    // One directed row: the input beat and, where typed, its result.
    typedef struct packed {
        logic [1:0] action;
        logic [7:0] rx_byte;
        logic [6:0] node_address;
        logic       typed;
        reply_t     want;
    } row_t;

    // Ways a generated reply frame can be broken.
    typedef enum int {
        FAULT_NONE,
        FAULT_STX,
        FAULT_ADDR,
        FAULT_TYPE,
        FAULT_TIMEOUT,
        FAULT_REPOLL,
        FAULT_UNUSED
    } fault_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = 16'h0000;  // [7:0] rx_byte, [14:8] node_address, [15] zero
    logic [1:0]  s_axis_tuser = 2'd0;      // [1:0] action
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;             // [7:0] data_byte, [15:8] data_index
    logic [1:0]  m_axis_tuser;             // [1:0] kind

    // Predictor state of the frame parser.
    logic       rx_armed = 1'b0;
    ps_t        hunt_state = PS_SYN1;
    logic [6:0] poll_addr = 7'd0;
    logic [7:0] data_pos = 8'd0;

    reply_t pending_replies[$];

    bit steady = 1'b0;
    bit long_hold_req = 1'b0;
    int cycle_count = 0;
    int beats_in = 0;
    int replies_seen = 0;
    int data_replies = 0;
    int end_replies = 0;
    int frames_sent = 0;
    int long_holds = 0;
    int mismatches = 0;
    int unexpected = 0;

    // Directed rows: reset behavior, every action, escapes, faults and extremes.
    row_t directed_rows [0:N_DIRECTED-1] = '{
        {ACT_BYTE,    FR_SYN,     7'h00, 1'b1, KIND_NONE, 8'h00, 8'h00},
        {ACT_UNUSED,  8'hA5,      7'h7F, 1'b1, KIND_NONE, 8'h00, 8'h00},
        {ACT_TIMEOUT, 8'h00,      7'h00, 1'b1, KIND_NONE, 8'h00, 8'h00},
        {ACT_POLL,    8'h00,      7'h7F, 1'b1, KIND_NONE, 8'h00, 8'h00},
        {ACT_BYTE,    FR_SYN,     7'h00, 1'b1, KIND_NONE, 8'h00, 8'h00},
        {ACT_BYTE,    8'h00,      7'h7F, 1'b1, KIND_NONE, 8'h00, 8'h00},
        {ACT_BYTE,    FR_SYN,     7'h00, 1'b1, KIND_NONE, 8'h00, 8'h00},
        {ACT_BYTE,    FR_STX,     7'h00, 1'b1, KIND_NONE, 8'h00, 8'h00},
        {ACT_BYTE,    8'hC0,      7'h00, 1'b1, KIND_NONE, 8'h00, 8'h00},
        {ACT_BYTE,    TYPE_REPLY, 7'h00, 1'b1, KIND_NONE, 8'h00, 8'h00},
        {ACT_BYTE,    8'h00,      7'h00, 1'b1, KIND_DATA, 8'h00, 8'h00},
        {ACT_BYTE,    FR_DLE,     7'h00, 1'b1, KIND_NONE, 8'h00, 8'h00},
        {ACT_BYTE,    FR_ETX,     7'h00, 1'b1, KIND_DATA, 8'h03, 8'h01},
        {ACT_BYTE,    FR_DLE,     7'h00, 1'b1, KIND_NONE, 8'h00, 8'h00},
        {ACT_BYTE,    FR_DLE,     7'h00, 1'b1, KIND_DATA, 8'h10, 8'h02},
        {ACT_BYTE,    FR_SYN,     7'h00, 1'b1, KIND_DATA, 8'hFF, 8'h03},
        {ACT_BYTE,    FR_ETX,     7'h00, 1'b1, KIND_END,  8'h00, 8'h00},
        {ACT_BYTE,    8'h7E,      7'h00, 1'b1, KIND_NONE, 8'h00, 8'h00},
        {ACT_POLL,    8'hFF,      7'h01, 1'b1, KIND_NONE, 8'h00, 8'h00},
        {ACT_BYTE,    FR_SYN,     7'h00, 1'b1, KIND_NONE, 8'h00, 8'h00},
        {ACT_BYTE,    FR_SYN,     7'h00, 1'b1, KIND_NONE, 8'h00, 8'h00},
        {ACT_BYTE,    8'h05,      7'h00, 1'b1, KIND_NONE, 8'h00, 8'h00},
        {ACT_BYTE,    FR_SYN,     7'h00, 1'b0, KIND_NONE, 8'h00, 8'h00},
        {ACT_POLL,    8'h00,      7'h00, 1'b0, KIND_NONE, 8'h00, 8'h00},
        {ACT_BYTE,    FR_SYN,     7'h00, 1'b0, KIND_NONE, 8'h00, 8'h00},
        {ACT_BYTE,    FR_STX,     7'h00, 1'b0, KIND_NONE, 8'h00, 8'h00},
        {ACT_BYTE,    8'h42,      7'h00, 1'b0, KIND_NONE, 8'h00, 8'h00},
        {ACT_BYTE,    TYPE_REPLY, 7'h00, 1'b0, KIND_NONE, 8'h00, 8'h00},
        {ACT_TIMEOUT, 8'h00,      7'h00, 1'b1, KIND_NONE, 8'h00, 8'h00}
    };

    polled_node_response_deframer_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock with an 8 ns period.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Advances the parser prediction by one input beat and returns its result.
    function automatic reply_t deframe_step(input logic [1:0] action,
                                            input logic [7:0] rx,
                                            input logic [6:0] addr);
        reply_t r;
        ps_t nxt;
        r = '0;
        nxt = PS_SYN1;
        if (action == ACT_POLL)
        begin
            rx_armed = 1'b1;
            poll_addr = addr;
        end
        else if (action == ACT_TIMEOUT)
        begin
            rx_armed = 1'b0;
            hunt_state = PS_SYN1;
        end
        else if (action == ACT_BYTE && rx_armed)
        begin
            case (hunt_state)
                PS_SYN1: if (rx == FR_SYN) nxt = PS_SYN2;
                PS_SYN2: nxt = (rx == FR_SYN) ? PS_STX : PS_SYN2;
                PS_STX:  if (rx == FR_STX) nxt = PS_ADDR;
                PS_ADDR: if (rx == {1'b0, poll_addr} + ADDR_OFFSET) nxt = PS_TYPE;
                PS_TYPE:
                begin
                    // The index restarts on any type byte, matching or not.
                    data_pos = 8'd0;
                    if (rx == TYPE_REPLY) nxt = PS_DATA;
                end
                PS_DATA:
                begin
                    if (rx == FR_DLE)
                        nxt = PS_ESC;
                    else if (rx == FR_ETX)
                    begin
                        r.kind = KIND_END;
                        rx_armed = 1'b0;
                    end
                    else
                    begin
                        r = {KIND_DATA, rx, data_pos};
                        data_pos = data_pos + 8'd1;
                        nxt = PS_DATA;
                    end
                end
                PS_ESC:
                begin
                    r = {KIND_DATA, rx, data_pos};
                    data_pos = data_pos + 8'd1;
                    nxt = PS_DATA;
                end
                default: nxt = PS_SYN1;
            endcase
            hunt_state = nxt;
        end
        return r;
    endfunction

    // Offers one input beat, waits for it to be taken and records its result.
    task automatic push_beat(input logic [1:0] action, input logic [7:0] rx,
                             input logic [6:0] addr, input bit typed, input reply_t want);
        reply_t predicted;
        if (!steady && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, addr, rx};
        s_axis_tuser <= action;
        do @(posedge clk); while (!s_axis_tready);
        predicted = deframe_step(action, rx, addr);
        pending_replies.push_back(typed ? want : predicted);
        beats_in++;
    endtask

    task automatic push_byte(input logic [7:0] rx);
        push_beat(ACT_BYTE, rx, 7'($urandom_range(0, 127)), 1'b0, '0);
    endtask

    task automatic push_ctrl(input logic [1:0] action, input logic [6:0] addr);
        push_beat(action, 8'($urandom_range(0, 255)), addr, 1'b0, '0);
    endtask

    // Random byte guaranteed to differ from the given one.
    function automatic logic [7:0] other_than(input logic [7:0] v);
        logic [7:0] r;
        do r = 8'($urandom_range(0, 255)); while (r == v);
        return r;
    endfunction

    // Sender pause: no beat is offered until every result has come back.
    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pending_replies.size() != 0);
    endtask

    // Sends a poll and a node reply frame, optionally broken in one place.
    task automatic send_reply(input logic [6:0] addr, input int n_data, input fault_t fault);
        logic [7:0] tag;
        logic [7:0] b;
        int cut;
        tag = {1'b0, addr} + ADDR_OFFSET;
        cut = $urandom_range(0, n_data);
        push_ctrl(ACT_POLL, addr);
        if ($urandom_range(0, 3) == 0) push_byte(other_than(FR_SYN));
        push_byte(FR_SYN);
        // Line noise between the two SYN bytes is skipped.
        if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 2)) push_byte(other_than(FR_SYN));
        push_byte(FR_SYN);
        push_byte(fault == FAULT_STX ? other_than(FR_STX) : FR_STX);
        push_byte(fault == FAULT_ADDR ? other_than(tag) : tag);
        push_byte(fault == FAULT_TYPE ? other_than(TYPE_REPLY) : TYPE_REPLY);
        for (int i = 0; i < n_data; i++)
        begin
            if (i == cut)
            begin
                if (fault == FAULT_TIMEOUT)
                begin
                    push_ctrl(ACT_TIMEOUT, 7'($urandom_range(0, 127)));
                    frames_sent++;
                    return;
                end
                if (fault == FAULT_REPOLL) push_ctrl(ACT_POLL, 7'($urandom_range(0, 127)));
                if (fault == FAULT_UNUSED) push_ctrl(ACT_UNUSED, 7'($urandom_range(0, 127)));
            end
            // DLE and ETX bytes inside the payload must be escaped; others sometimes are.
            b = 8'($urandom_range(0, 255));
            if (b == FR_DLE || b == FR_ETX || $urandom_range(0, 7) == 0) push_byte(FR_DLE);
            push_byte(b);
        end
        push_byte(FR_ETX);
        frames_sent++;
    endtask

    // Receiver: random short stalls, plus one long hold whenever requested.
    initial
    begin
        int hold_left;
        hold_left = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                long_holds++;
                hold_left = LONG_HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end
            else if (!steady && $urandom_range(0, 4) == 0)
            begin
                hold_left = $urandom_range(0, 2);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Result checker: every accepted result beat against the oldest prediction.
    always @(posedge clk)
    begin
        reply_t got;
        reply_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[15:8]};
            replies_seen++;
            if (got.kind == KIND_DATA) data_replies++;
            if (got.kind == KIND_END) end_replies++;
            if (pending_replies.size() == 0)
            begin
                unexpected++;
                if (mismatches + unexpected <= REPORT_LIMIT)
                    $display("ERROR: unexpected result beat: kind %0d byte %02h idx %0d",
                             got.kind, got.data_byte, got.data_index);
            end
            else
            begin
                want = pending_replies.pop_front();
                if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
                    got.data_index !== want.data_index)
                begin
                    mismatches++;
                    if (mismatches + unexpected <= REPORT_LIMIT)
                        $display("ERROR: result %0d: expected kind %0d byte %02h idx %0d, %s",
                                 replies_seen, want.kind, want.data_byte, want.data_index,
                                 $sformatf("got kind %0d byte %02h idx %0d",
                                           got.kind, got.data_byte, got.data_index));
                end
            end
        end
    end

    // Watchdog on the total run length.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("ERROR: timeout after %0d cycles", CYCLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // Stimulus: reset, directed rows, then random frames.
    initial
    begin
        int errors;
        int n_frames;
        fault_t fault;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
            push_beat(directed_rows[i].action, directed_rows[i].rx_byte,
                      directed_rows[i].node_address, directed_rows[i].typed,
                      directed_rows[i].want);
        wait_for_drain();

        // Long output stall while the sender keeps offering beats.
        long_hold_req = 1'b1;
        n_frames = 0;
        while (beats_in < ITEM_TARGET)
        begin
            if (beats_in >= ITEM_TARGET - STEADY_TAIL) steady = 1'b1;
            fault = ($urandom_range(0, 9) < 6) ? FAULT_NONE : fault_t'($urandom_range(1, 6));
            send_reply(7'($urandom_range(0, 127)), $urandom_range(0, 10), fault);
            n_frames++;

            // Stray beats between frames, each with a random action code.
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 3))
                    push_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                              7'($urandom_range(0, 127)), 1'b0, '0);

            // One long frame so the data index wraps, under a second long stall.
            if (n_frames == 2)
            begin
                long_hold_req = 1'b1;
                send_reply(7'($urandom_range(0, 127)), WRAP_DATA_LEN, FAULT_NONE);
            end
            if (n_frames % 12 == 0) wait_for_drain();
        end

        // Let every result come back, then watch for stray result beats before the summary.
        wait_for_drain();
        repeat (8) @(posedge clk);
        errors = mismatches + unexpected + pending_replies.size();
        $display("Summary: %0d input beats, %0d result beats (%0d data, %0d end of message).",
                 beats_in, replies_seen, data_replies, end_replies);
        $display("Summary: %0d frames with faults and index wrap, %0d long stalls, %0d errors.",
                 frames_sent, long_holds, errors);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
